>>> rtl/pl0_pkg.sv
// ----------------------------------------------------------------------------
// pl0_pkg: shared types and codes of the p-code execute core
// Beat structs, opcode and subcode values, result codes, sequencer states
// and the operation select of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package pl0_pkg;

    typedef struct packed {
        logic        [3:0]  opcode;
        logic        [3:0]  level_diff;
        logic signed [31:0] operand;
        logic signed [31:0] read_value;
    } t_in_beat;

    typedef struct packed {
        logic        [10:0] next_pc;
        logic               halted;
        logic        [1:0]  io_event;
        logic signed [31:0] print_value;
        logic        [1:0]  fault;
    } t_out_beat;

    localparam logic [3:0] OP_LIT  = 4'd0;
    localparam logic [3:0] OP_OPR  = 4'd1;
    localparam logic [3:0] OP_LOD  = 4'd2;
    localparam logic [3:0] OP_STO  = 4'd3;
    localparam logic [3:0] OP_CAL  = 4'd4;
    localparam logic [3:0] OP_INT  = 4'd5;
    localparam logic [3:0] OP_JMP  = 4'd6;
    localparam logic [3:0] OP_JPC  = 4'd7;
    localparam logic [3:0] OP_LODI = 4'd8;
    localparam logic [3:0] OP_STI  = 4'd9;

    localparam logic [31:0] SUB_RET   = 32'd0;
    localparam logic [31:0] SUB_NEG   = 32'd1;
    localparam logic [31:0] SUB_ADD   = 32'd2;
    localparam logic [31:0] SUB_SUB   = 32'd3;
    localparam logic [31:0] SUB_MUL   = 32'd4;
    localparam logic [31:0] SUB_DIV   = 32'd5;
    localparam logic [31:0] SUB_ODD   = 32'd6;
    localparam logic [31:0] SUB_EQ    = 32'd8;
    localparam logic [31:0] SUB_NE    = 32'd9;
    localparam logic [31:0] SUB_LT    = 32'd10;
    localparam logic [31:0] SUB_GE    = 32'd11;
    localparam logic [31:0] SUB_GT    = 32'd12;
    localparam logic [31:0] SUB_LE    = 32'd13;
    localparam logic [31:0] SUB_PRINT = 32'd14;
    localparam logic [31:0] SUB_NL    = 32'd15;
    localparam logic [31:0] SUB_READ  = 32'd16;

    localparam logic [1:0] IO_NONE  = 2'd0;
    localparam logic [1:0] IO_PRINT = 2'd1;
    localparam logic [1:0] IO_NL    = 2'd2;
    localparam logic [1:0] IO_READ  = 2'd3;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_OVER  = 2'd1;
    localparam logic [1:0] FAULT_UNDER = 2'd2;
    localparam logic [1:0] FAULT_DIV0  = 2'd3;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_MUL, ALU_NEG, ALU_ODD,
        ALU_EQ, ALU_NE, ALU_LT, ALU_GE, ALU_GT, ALU_LE
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CHECK, ST_RDA, ST_RDB, ST_POST, ST_CHAIN,
        ST_LINK, ST_ADDR, ST_LOAD, ST_CALL0, ST_CALL1, ST_CALL2, ST_DIV, ST_FIN
    } t_state;

    // Maps an operate subcode to the arithmetic unit's operation.
    function automatic t_alu_op alu_op_of(input logic [31:0] sub);
        t_alu_op op;
        op = ALU_ADD;
        unique case (sub)
            SUB_SUB: op = ALU_SUB;
            SUB_MUL: op = ALU_MUL;
            SUB_NEG: op = ALU_NEG;
            SUB_ODD: op = ALU_ODD;
            SUB_EQ:  op = ALU_EQ;
            SUB_NE:  op = ALU_NE;
            SUB_LT:  op = ALU_LT;
            SUB_GE:  op = ALU_GE;
            SUB_GT:  op = ALU_GT;
            SUB_LE:  op = ALU_LE;
            default: op = ALU_ADD;
        endcase
        return op;
    endfunction

endpackage

>>> rtl/pl0_stack_machine_execute_core.sv
// ----------------------------------------------------------------------------
// pl0_stack_machine_execute_core: PL/0 p-code execute core
// Runs one p-code instruction per input beat against an internal data stack
// and reports the next pc, halt, I/O event and fault in one output beat.
// ----------------------------------------------------------------------------
// Usage. The input channel (i_in_valid / o_in_stall / i_in_data) carries one
// instruction per beat together with the value that a read instruction
// pushes. The output channel (o_out_valid / i_out_stall / o_out_data) returns
// exactly one beat per instruction, in order.
// Sequencing. Stack operations make one or two stack reads, and each static
// level walked adds one stack memory read and one link check. A divide
// waits for the iterative divider, whose 32 quotient bits come one per
// cycle. The stack memory has a single read port, so the reads of an
// instruction run one after another. The core holds o_in_stall high while an
// instruction is in work, so it runs one instruction at a time.
// Reset. After reset the core sweeps the stack memory to zero, one word a
// cycle, with o_in_stall high throughout.
// Stall. A finished result sits in the output register while the receiver
// stalls; a following instruction is accepted and worked on, and only its
// result waits until the register frees up.
// ----------------------------------------------------------------------------
module pl0_stack_machine_execute_core #(
    parameter int STACK_DEPTH = 512,
    parameter int CODE_DEPTH  = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pl0_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pl0_pkg::t_out_beat o_out_data
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int PCW = $clog2(CODE_DEPTH);
    localparam logic [32:0] SD33 = 33'(STACK_DEPTH);
    localparam logic [32:0] CD33 = 33'(CODE_DEPTH);

    // Sequencer and architectural state.
    pl0_pkg::t_state    r_state, n_state;
    logic [3:0]         r_op,    n_op;
    logic [3:0]         r_lv,    n_lv;
    logic [31:0]        r_opnd,  n_opnd;
    logic [31:0]        r_rd,    n_rd;
    logic [SPW-1:0]     r_t,     n_t;
    logic [AW-1:0]      r_fb,    n_fb;
    logic [PCW-1:0]     r_pc,    n_pc;
    logic [PCW-1:0]     r_p,     n_p;
    logic [31:0]        r_a,     n_a;
    logic [31:0]        r_b,     n_b;
    logic [AW-1:0]      r_base,  n_base;
    logic [1:0]         r_fault, n_fault;
    logic [1:0]         r_io,    n_io;
    logic [31:0]        r_pv,    n_pv;
    logic [AW-1:0]      r_clr,   n_clr;
    logic               r_ov,    n_ov;
    pl0_pkg::t_out_beat r_out,   n_out;

    // Stack memory port.
    logic               we;
    logic [AW-1:0]      waddr;
    logic [31:0]        wdata;
    logic [AW-1:0]      raddr;
    logic [31:0]        rdata;

    // Shared units.
    pl0_pkg::t_alu_op   alu_op;
    logic [31:0]        alu_x;
    logic [31:0]        alu_res;
    logic               div_start;
    logic               div_done;
    logic [31:0]        div_quot;

    // Address and bound helpers.
    logic [SPW-1:0]     t_p1, t_m1, t_m2;
    logic [SPW:0]       t_p2w;
    logic [AW:0]        fb_p1, fb_p2;
    logic [PCW:0]       pc_inc;
    logic [32:0]        nt33;
    logic [31:0]        addr_off;
    logic [32:0]        addr33;
    logic               addr_ok;
    logic               is_ret, is_unary, is_bin, needs_b;
    logic               t_full;
    logic [PCW-1:0]     commit_pc;
    logic [31:0]        pc32;
    logic               fin_go;

    function automatic logic code_ok(input logic [31:0] v);
        return !v[31] && ({1'b0, v} < CD33);
    endfunction

    function automatic logic stack_ok(input logic [31:0] v);
        return !v[31] && ({1'b0, v} < SD33);
    endfunction

    assign t_p1   = r_t + SPW'(1);
    assign t_m1   = r_t - SPW'(1);
    assign t_m2   = r_t - SPW'(2);
    assign t_p2w  = {1'b0, r_t} + (SPW+1)'(2);
    assign fb_p1  = {1'b0, r_fb} + (AW+1)'(1);
    assign fb_p2  = {1'b0, r_fb} + (AW+1)'(2);
    assign pc_inc = {1'b0, r_pc} + (PCW+1)'(1);
    assign nt33   = {r_opnd[31], r_opnd} + 33'(r_t);
    assign t_full = (r_t >= SPW'(STACK_DEPTH));

    assign is_ret   = (r_opnd == pl0_pkg::SUB_RET);
    assign is_unary = (r_opnd == pl0_pkg::SUB_NEG) || (r_opnd == pl0_pkg::SUB_ODD) ||
                      (r_opnd == pl0_pkg::SUB_PRINT);
    assign is_bin   = ((r_opnd >= pl0_pkg::SUB_ADD) && (r_opnd <= pl0_pkg::SUB_DIV)) ||
                      ((r_opnd >= pl0_pkg::SUB_EQ) && (r_opnd <= pl0_pkg::SUB_LE));
    assign needs_b  = ((r_op == pl0_pkg::OP_OPR) && (is_ret || is_bin)) ||
                      (r_op == pl0_pkg::OP_STI);

    // Data address: frame base found by the chain walk plus a signed offset.
    assign addr_off = (r_op == pl0_pkg::OP_LODI) ? r_a :
                      (r_op == pl0_pkg::OP_STI)  ? r_b : r_opnd;
    assign addr33   = {addr_off[31], addr_off} + 33'(r_base);
    assign addr_ok  = !addr33[32] && (addr33 < SD33);

    // Binary operations take the deeper word as the left operand.
    assign alu_op = pl0_pkg::alu_op_of(r_opnd);
    assign alu_x  = is_bin ? r_b : r_a;

    assign fin_go    = !r_ov || !i_out_stall;
    assign commit_pc = (r_fault == pl0_pkg::FAULT_NONE) ? r_p : r_pc;
    assign pc32      = 32'(commit_pc);

    pl0_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    pl0_alu u_alu (
        .i_op  (alu_op),
        .i_x   (alu_x),
        .i_y   (r_a),
        .o_res (alu_res)
    );

    pl0_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_b),
        .i_divisor  (r_a),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_lv      = r_lv;
        n_opnd    = r_opnd;
        n_rd      = r_rd;
        n_t       = r_t;
        n_fb      = r_fb;
        n_pc      = r_pc;
        n_p       = r_p;
        n_a       = r_a;
        n_b       = r_b;
        n_base    = r_base;
        n_fault   = r_fault;
        n_io      = r_io;
        n_pv      = r_pv;
        n_clr     = r_clr;
        n_out     = r_out;
        n_ov      = (r_ov && !i_out_stall) ? 1'b0 : r_ov;
        we        = 1'b0;
        waddr     = r_t[AW-1:0];
        wdata     = 32'd0;
        raddr     = t_m1[AW-1:0];
        div_start = 1'b0;

        unique case (r_state)
            pl0_pkg::ST_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(STACK_DEPTH - 1)) begin
                    n_state = pl0_pkg::ST_IDLE;
                end
            end

            pl0_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_data.opcode;
                    n_lv    = i_in_data.level_diff;
                    n_opnd  = i_in_data.operand;
                    n_rd    = i_in_data.read_value;
                    n_p     = (pc_inc >= (PCW+1)'(CODE_DEPTH)) ? '0 : pc_inc[PCW-1:0];
                    n_fault = pl0_pkg::FAULT_NONE;
                    n_io    = pl0_pkg::IO_NONE;
                    n_pv    = 32'd0;
                    n_state = pl0_pkg::ST_CHECK;
                end
            end

            pl0_pkg::ST_CHECK: begin
                n_state = pl0_pkg::ST_FIN;
                n_base  = r_fb;
                unique case (r_op)
                    pl0_pkg::OP_LIT: begin
                        if (t_full) begin
                            n_fault = pl0_pkg::FAULT_OVER;
                        end else begin
                            we    = 1'b1;
                            wdata = r_opnd;
                            n_t   = t_p1;
                        end
                    end
                    pl0_pkg::OP_OPR: begin
                        if (is_ret) begin
                            if (fb_p2 >= (AW+1)'(STACK_DEPTH)) begin
                                n_fault = pl0_pkg::FAULT_UNDER;
                            end else begin
                                raddr   = fb_p1[AW-1:0];
                                n_state = pl0_pkg::ST_RDA;
                            end
                        end else if (is_unary) begin
                            if (r_t == '0) begin
                                n_fault = pl0_pkg::FAULT_UNDER;
                            end else begin
                                n_state = pl0_pkg::ST_RDA;
                            end
                        end else if (is_bin) begin
                            if (r_t < SPW'(2)) begin
                                n_fault = pl0_pkg::FAULT_UNDER;
                            end else begin
                                n_state = pl0_pkg::ST_RDA;
                            end
                        end else if (r_opnd == pl0_pkg::SUB_NL) begin
                            n_io = pl0_pkg::IO_NL;
                        end else if (r_opnd == pl0_pkg::SUB_READ) begin
                            if (t_full) begin
                                n_fault = pl0_pkg::FAULT_OVER;
                            end else begin
                                we    = 1'b1;
                                wdata = r_rd;
                                n_t   = t_p1;
                                n_io  = pl0_pkg::IO_READ;
                            end
                        end
                    end
                    pl0_pkg::OP_LOD: begin
                        if (t_full) begin
                            n_fault = pl0_pkg::FAULT_OVER;
                        end else begin
                            n_state = (r_lv == 4'd0) ? pl0_pkg::ST_ADDR : pl0_pkg::ST_CHAIN;
                        end
                    end
                    pl0_pkg::OP_STO, pl0_pkg::OP_JPC, pl0_pkg::OP_LODI: begin
                        if (r_t == '0) begin
                            n_fault = pl0_pkg::FAULT_UNDER;
                        end else begin
                            n_state = pl0_pkg::ST_RDA;
                        end
                    end
                    pl0_pkg::OP_CAL: begin
                        if (t_p2w >= (SPW+1)'(STACK_DEPTH)) begin
                            n_fault = pl0_pkg::FAULT_OVER;
                        end else begin
                            n_state = (r_lv == 4'd0) ? pl0_pkg::ST_CALL0 : pl0_pkg::ST_CHAIN;
                        end
                    end
                    pl0_pkg::OP_INT: begin
                        if (nt33[32]) begin
                            n_fault = pl0_pkg::FAULT_UNDER;
                        end else if (nt33 > SD33) begin
                            n_fault = pl0_pkg::FAULT_OVER;
                        end else begin
                            n_t = nt33[SPW-1:0];
                        end
                    end
                    pl0_pkg::OP_JMP: begin
                        if (code_ok(r_opnd)) begin
                            n_p = r_opnd[PCW-1:0];
                        end else begin
                            n_fault = pl0_pkg::FAULT_UNDER;
                        end
                    end
                    pl0_pkg::OP_STI: begin
                        if (r_t < SPW'(2)) begin
                            n_fault = pl0_pkg::FAULT_UNDER;
                        end else begin
                            n_state = pl0_pkg::ST_RDA;
                        end
                    end
                    default: begin
                        n_state = pl0_pkg::ST_FIN;
                    end
                endcase
            end

            pl0_pkg::ST_RDA: begin
                n_a = rdata;
                if (needs_b) begin
                    raddr   = (r_op == pl0_pkg::OP_OPR && is_ret) ? fb_p2[AW-1:0]
                                                                  : t_m2[AW-1:0];
                    n_state = pl0_pkg::ST_RDB;
                end else begin
                    n_state = pl0_pkg::ST_POST;
                end
            end

            pl0_pkg::ST_RDB: begin
                n_b     = rdata;
                n_state = pl0_pkg::ST_POST;
            end

            pl0_pkg::ST_POST: begin
                n_state = pl0_pkg::ST_FIN;
                n_base  = r_fb;
                priority case (r_op)
                    pl0_pkg::OP_OPR: begin
                        if (is_ret) begin
                            // Return: r_a holds the saved frame base, r_b the return pc.
                            if (!code_ok(r_b) || !stack_ok(r_a)) begin
                                n_fault = pl0_pkg::FAULT_UNDER;
                            end else begin
                                n_t  = SPW'(r_fb);
                                n_p  = r_b[PCW-1:0];
                                n_fb = r_a[AW-1:0];
                            end
                        end else if (r_opnd == pl0_pkg::SUB_PRINT) begin
                            n_io = pl0_pkg::IO_PRINT;
                            n_pv = r_a;
                            n_t  = t_m1;
                        end else if (is_unary) begin
                            we    = 1'b1;
                            waddr = t_m1[AW-1:0];
                            wdata = alu_res;
                        end else if (r_opnd == pl0_pkg::SUB_DIV) begin
                            if (r_a == 32'd0) begin
                                n_fault = pl0_pkg::FAULT_DIV0;
                            end else begin
                                div_start = 1'b1;
                                n_state   = pl0_pkg::ST_DIV;
                            end
                        end else begin
                            we    = 1'b1;
                            waddr = t_m2[AW-1:0];
                            wdata = alu_res;
                            n_t   = t_m1;
                        end
                    end
                    pl0_pkg::OP_JPC: begin
                        // A taken branch checks its target; a branch not taken does not.
                        if (r_a == 32'd0 && !code_ok(r_opnd)) begin
                            n_fault = pl0_pkg::FAULT_UNDER;
                        end else begin
                            if (r_a == 32'd0) begin
                                n_p = r_opnd[PCW-1:0];
                            end
                            n_t = t_m1;
                        end
                    end
                    default: begin
                        n_state = (r_lv == 4'd0) ? pl0_pkg::ST_ADDR : pl0_pkg::ST_CHAIN;
                    end
                endcase
            end

            pl0_pkg::ST_CHAIN: begin
                raddr   = r_base;
                n_state = pl0_pkg::ST_LINK;
            end

            pl0_pkg::ST_LINK: begin
                if (!stack_ok(rdata)) begin
                    n_fault = pl0_pkg::FAULT_UNDER;
                    n_state = pl0_pkg::ST_FIN;
                end else begin
                    n_base = rdata[AW-1:0];
                    n_lv   = r_lv - 4'd1;
                    if (r_lv == 4'd1) begin
                        n_state = (r_op == pl0_pkg::OP_CAL) ? pl0_pkg::ST_CALL0
                                                            : pl0_pkg::ST_ADDR;
                    end else begin
                        n_state = pl0_pkg::ST_CHAIN;
                    end
                end
            end

            pl0_pkg::ST_ADDR: begin
                n_state = pl0_pkg::ST_FIN;
                raddr   = addr33[AW-1:0];
                if (!addr_ok) begin
                    n_fault = pl0_pkg::FAULT_UNDER;
                end else if (r_op == pl0_pkg::OP_LOD || r_op == pl0_pkg::OP_LODI) begin
                    n_state = pl0_pkg::ST_LOAD;
                end else begin
                    we    = 1'b1;
                    waddr = addr33[AW-1:0];
                    wdata = r_a;
                    n_t   = (r_op == pl0_pkg::OP_STI) ? t_m2 : t_m1;
                end
            end

            pl0_pkg::ST_LOAD: begin
                we      = 1'b1;
                wdata   = rdata;
                n_state = pl0_pkg::ST_FIN;
                if (r_op == pl0_pkg::OP_LOD) begin
                    n_t = t_p1;
                end else begin
                    waddr = t_m1[AW-1:0];
                end
            end

            // Call frame: static link, dynamic link, return address.
            pl0_pkg::ST_CALL0: begin
                if (!code_ok(r_opnd)) begin
                    n_fault = pl0_pkg::FAULT_UNDER;
                    n_state = pl0_pkg::ST_FIN;
                end else begin
                    we      = 1'b1;
                    wdata   = 32'(r_base);
                    n_state = pl0_pkg::ST_CALL1;
                end
            end

            pl0_pkg::ST_CALL1: begin
                we      = 1'b1;
                waddr   = t_p1[AW-1:0];
                wdata   = 32'(r_fb);
                n_state = pl0_pkg::ST_CALL2;
            end

            pl0_pkg::ST_CALL2: begin
                we      = 1'b1;
                waddr   = t_p2w[AW-1:0];
                wdata   = 32'(r_p);
                n_fb    = r_t[AW-1:0];
                n_p     = r_opnd[PCW-1:0];
                n_state = pl0_pkg::ST_FIN;
            end

            pl0_pkg::ST_DIV: begin
                if (div_done) begin
                    we      = 1'b1;
                    waddr   = t_m2[AW-1:0];
                    wdata   = div_quot;
                    n_t     = t_m1;
                    n_state = pl0_pkg::ST_FIN;
                end
            end

            pl0_pkg::ST_FIN: begin
                if (fin_go) begin
                    n_ov              = 1'b1;
                    n_pc              = commit_pc;
                    n_out.next_pc     = pc32[10:0];
                    n_out.halted      = (commit_pc == '0);
                    n_out.io_event    = r_io;
                    n_out.print_value = r_pv;
                    n_out.fault       = r_fault;
                    n_state           = pl0_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = pl0_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pl0_pkg::ST_CLEAR;
            r_t     <= '0;
            r_fb    <= '0;
            r_pc    <= '0;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_t     <= n_t;
            r_fb    <= n_fb;
            r_pc    <= n_pc;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
        r_op    <= n_op;
        r_lv    <= n_lv;
        r_opnd  <= n_opnd;
        r_rd    <= n_rd;
        r_p     <= n_p;
        r_a     <= n_a;
        r_b     <= n_b;
        r_base  <= n_base;
        r_fault <= n_fault;
        r_io    <= n_io;
        r_pv    <= n_pv;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != pl0_pkg::ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // The stack top never runs past the stack.
    a_top_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t <= SPW'(STACK_DEPTH))
        else $error("stack top beyond stack depth");

    // A faulting instruction leaves the program counter where it was.
    a_fault_keeps_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pl0_pkg::ST_FIN && fin_go && r_fault != pl0_pkg::FAULT_NONE)
        |=> (r_pc == $past(r_pc)))
        else $error("pc moved on a faulting instruction");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == pl0_pkg::ST_DIV))
        else $error("divider finished outside the divide step");

    // A result beat is only written into a free or draining output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |=> (r_ov && $stable(r_out)))
        else $error("stalled result overwritten");
`endif

endmodule

>>> rtl/pl0_ram.sv
// ----------------------------------------------------------------------------
// pl0_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pl0_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pl0_alu.sv
// ----------------------------------------------------------------------------
// pl0_alu: shared arithmetic and compare unit
// Add, subtract, multiply, negate, odd test and the six signed compares.
// ----------------------------------------------------------------------------
module pl0_alu (
    input  pl0_pkg::t_alu_op i_op,
    input  logic [31:0]      i_x,
    input  logic [31:0]      i_y,
    output logic [31:0]      o_res
);

    logic [32:0] diff;
    logic [31:0] prod;
    logic        lt;
    logic        eq;

    assign diff = {i_x[31], i_x} - {i_y[31], i_y};
    assign prod = i_x * i_y;
    assign lt   = diff[32];
    assign eq   = (i_x == i_y);

    always_comb begin
        unique case (i_op)
            pl0_pkg::ALU_ADD: o_res = i_x + i_y;
            pl0_pkg::ALU_SUB: o_res = diff[31:0];
            pl0_pkg::ALU_MUL: o_res = prod;
            pl0_pkg::ALU_NEG: o_res = 32'd0 - i_x;
            // Remainder by two truncates toward zero, so it keeps the sign.
            pl0_pkg::ALU_ODD: o_res = !i_x[0] ? 32'd0 : (i_x[31] ? 32'hFFFF_FFFF : 32'd1);
            pl0_pkg::ALU_EQ:  o_res = {31'd0, eq};
            pl0_pkg::ALU_NE:  o_res = {31'd0, !eq};
            pl0_pkg::ALU_LT:  o_res = {31'd0, lt};
            pl0_pkg::ALU_GE:  o_res = {31'd0, !lt};
            pl0_pkg::ALU_GT:  o_res = {31'd0, !lt && !eq};
            pl0_pkg::ALU_LE:  o_res = {31'd0, lt || eq};
            default:          o_res = i_x + i_y;
        endcase
    end

endmodule

>>> rtl/pl0_div.sv
// ----------------------------------------------------------------------------
// pl0_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module pl0_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt,  n_cnt;
    logic [31:0] r_rem,  n_rem;
    logic [31:0] r_q,    n_q;
    logic [31:0] r_d,    n_d;
    logic        r_neg,  n_neg;
    logic [32:0] shifted;
    logic [32:0] trial;

    assign shifted = {r_rem, r_q[31]};
    assign trial   = shifted - {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_d    = r_d;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd31;
            n_rem  = 32'd0;
            n_q    = i_dividend[31] ? 32'd0 - i_dividend : i_dividend;
            n_d    = i_divisor[31]  ? 32'd0 - i_divisor  : i_divisor;
            n_neg  = i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            if (!trial[32]) begin
                n_rem = trial[31:0];
                n_q   = {r_q[30:0], 1'b1};
            end else begin
                n_rem = shifted[31:0];
                n_q   = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_d   <= n_d;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? 32'd0 - r_q : r_q;

endmodule
